// File: rtl/pfc_pkg.sv
// Shared types, codes and constants for the packet field classifier.
// Used by pfc_mask_store and packet_field_classifier; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package pfc_pkg;

    // Table geometry
    localparam int NUM_LISTS   = 8;
    localparam int LIST_W      = 3;
    localparam int PORT_BYTES  = 8192;
    localparam int PORT_WORDS  = PORT_BYTES / 4;
    localparam int PORT_WORD_W = $clog2(PORT_WORDS);
    localparam int PORT_ADDR_W = LIST_W + PORT_WORD_W;
    localparam int IP_ENTRIES_DEF = 16;
    localparam int TADDR_W     = 11;

    // Item function codes
    localparam logic [1:0] FUNC_CLASSIFY  = 2'd0;
    localparam logic [1:0] FUNC_PORT_WR   = 2'd1;
    localparam logic [1:0] FUNC_MASK_WR   = 2'd2;
    localparam logic [1:0] FUNC_VALID_WR  = 2'd3;

    // Predicate codes
    localparam logic [4:0] PRED_TCP      = 5'd0;
    localparam logic [4:0] PRED_UDP      = 5'd1;
    localparam logic [4:0] PRED_ICMP     = 5'd2;
    localparam logic [4:0] PRED_IP0      = 5'd3;
    localparam logic [4:0] PRED_IP7      = 5'd10;
    localparam logic [4:0] PRED_PORT0    = 5'd11;
    localparam logic [4:0] PRED_PORT7    = 5'd18;
    localparam logic [4:0] PRED_REQUEST  = 5'd19;
    localparam logic [4:0] PRED_REPLY    = 5'd20;
    localparam logic [4:0] PRED_ERROR    = 5'd21;
    localparam logic [4:0] PRED_OTHER    = 5'd22;

    // IPv4 protocol numbers
    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    // ICMP type codes
    localparam logic [7:0] ICMP_ECHO_REPLY    = 8'd0;
    localparam logic [7:0] ICMP_UNREACH       = 8'd3;
    localparam logic [7:0] ICMP_QUENCH        = 8'd4;
    localparam logic [7:0] ICMP_REDIRECT      = 8'd5;
    localparam logic [7:0] ICMP_ECHO_REQ      = 8'd8;
    localparam logic [7:0] ICMP_ROUTER_SOL    = 8'd10;
    localparam logic [7:0] ICMP_TIME_EXCEED   = 8'd11;
    localparam logic [7:0] ICMP_PARAM_PROB    = 8'd12;
    localparam logic [7:0] ICMP_TSTAMP_REQ    = 8'd13;
    localparam logic [7:0] ICMP_TSTAMP_REPLY  = 8'd14;
    localparam logic [7:0] ICMP_INFO_REQ      = 8'd15;
    localparam logic [7:0] ICMP_INFO_REPLY    = 8'd16;
    localparam logic [7:0] ICMP_MASK_REQ      = 8'd17;
    localparam logic [7:0] ICMP_MASK_REPLY    = 8'd18;
    localparam logic [7:0] ICMP_ROUTER_ADV    = 8'd9;

    // Control state of the top level
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PORT,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // Mask word write toward the mask store (already range checked)
    typedef struct packed {
        logic                 en;
        logic [LIST_W-1:0]    list;
        logic [TADDR_W-1:0]   addr;
        logic [31:0]          data;
    } mask_wr_t;

    // Start of an IP list scan
    typedef struct packed {
        logic              start;
        logic [LIST_W-1:0] list;
        logic [31:0]       addr;
    } scan_req_t;

    // Scan status back to the top level
    typedef struct packed {
        logic done;
        logic hit;
    } scan_rsp_t;

    function automatic logic in_request_set(input logic [7:0] t);
        return t == ICMP_ECHO_REQ || t == ICMP_ROUTER_SOL || t == ICMP_TSTAMP_REQ ||
               t == ICMP_INFO_REQ || t == ICMP_MASK_REQ;
    endfunction

    function automatic logic in_reply_set(input logic [7:0] t);
        return t == ICMP_ECHO_REPLY || t == ICMP_ROUTER_ADV || t == ICMP_TSTAMP_REPLY ||
               t == ICMP_INFO_REPLY || t == ICMP_MASK_REPLY;
    endfunction

    function automatic logic in_error_set(input logic [7:0] t);
        return t == ICMP_UNREACH || t == ICMP_QUENCH || t == ICMP_REDIRECT ||
               t == ICMP_TIME_EXCEED || t == ICMP_PARAM_PROB;
    endfunction

endpackage

`default_nettype wire

// File: rtl/pfc_mask_store.sv
// IP list mask memory and the entry scan that walks it one word per cycle.
// Depends on pfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pfc_mask_store
    import pfc_pkg::*;
#(
    parameter int IP_ENTRIES = IP_ENTRIES_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire mask_wr_t              wr,
    input  wire scan_req_t             req,
    input  wire logic [IP_ENTRIES-1:0] valid_vec,
    output scan_rsp_t                  rsp
);

    localparam int ENT_W    = (IP_ENTRIES > 1) ? $clog2(IP_ENTRIES) : 1;
    localparam int MADDR_W  = LIST_W + ENT_W + 5;
    localparam int MDEPTH   = 1 << MADDR_W;
    localparam logic [ENT_W-1:0] ENT_LAST = ENT_W'(IP_ENTRIES - 1);

    logic [31:0]           mem [MDEPTH];
    logic [31:0]           rdata_reg;

    logic [LIST_W-1:0]     list_reg;
    logic [31:0]           addr_reg;
    logic [IP_ENTRIES-1:0] vec_reg;
    logic                  issue_on_reg, issue_on_next;
    logic [ENT_W-1:0]      ent_reg, ent_next;
    logic [1:0]            grp_reg, grp_next;
    logic                  rd_on_reg;
    logic [ENT_W-1:0]      rd_ent_reg;
    logic [1:0]            rd_grp_reg;
    logic                  ok_reg, ok_next;
    logic                  hit_reg, hit_next;

    logic [MADDR_W-1:0]    raddr;
    logic [MADDR_W-1:0]    waddr;
    logic [7:0]            iss_octet;
    logic [7:0]            rd_octet;
    logic                  mask_bit;
    logic                  ent_ok;
    logic                  entry_hit;
    logic                  last_issue;

    // Octet of the address that a mask group tests, first octet in group zero
    function automatic logic [7:0] octet_of(input logic [31:0] a, input logic [1:0] g);
        logic [7:0] o;
        case (g)
            2'd0:    o = a[31:24];
            2'd1:    o = a[23:16];
            2'd2:    o = a[15:8];
            default: o = a[7:0];
        endcase
        return o;
    endfunction

    // Form read and write addresses: list, entry, group word
    always_comb begin
        iss_octet  = octet_of(addr_reg, grp_reg);
        raddr      = {list_reg, ent_reg, grp_reg, iss_octet[7:5]};
        waddr      = {wr.list, wr.addr[ENT_W+4:5], wr.addr[4:0]};
        last_issue = (ent_reg == ENT_LAST) && (grp_reg == 2'd3);
    end

    // Memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[waddr] <= wr.data;
        end
        if (issue_on_reg) begin
            rdata_reg <= mem[raddr];
        end
    end

    // Test the octet bit of the returned word and fold it into the entry result
    always_comb begin
        rd_octet  = octet_of(addr_reg, rd_grp_reg);
        mask_bit  = rdata_reg[rd_octet[4:0]];
        ent_ok    = (rd_grp_reg == 2'd0) ? mask_bit : (ok_reg & mask_bit);
        entry_hit = (rd_grp_reg == 2'd3) && vec_reg[rd_ent_reg] && ent_ok;
        rsp.done  = rd_on_reg && (rd_ent_reg == ENT_LAST) && (rd_grp_reg == 2'd3);
        rsp.hit   = hit_reg | entry_hit;
    end

    // Advance the issue counters and the accumulators
    always_comb begin
        issue_on_next = issue_on_reg;
        ent_next      = ent_reg;
        grp_next      = grp_reg;
        ok_next       = ok_reg;
        hit_next      = hit_reg;
        if (req.start) begin
            issue_on_next = 1'b1;
            ent_next      = '0;
            grp_next      = '0;
            hit_next      = 1'b0;
        end else begin
            if (issue_on_reg) begin
                grp_next = grp_reg + 2'd1;
                if (grp_reg == 2'd3) begin
                    ent_next = ent_reg + ENT_W'(1);
                end
                if (last_issue) begin
                    issue_on_next = 1'b0;
                end
            end
            if (rd_on_reg) begin
                ok_next  = ent_ok;
                hit_next = hit_reg | entry_hit;
            end
        end
    end

    // Hold the scan context and step the pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_on_reg <= 1'b0;
            rd_on_reg    <= 1'b0;
        end else begin
            issue_on_reg <= issue_on_next;
            rd_on_reg    <= issue_on_reg && !req.start;
        end
        ent_reg    <= ent_next;
        grp_reg    <= grp_next;
        ok_reg     <= ok_next;
        hit_reg    <= hit_next;
        rd_ent_reg <= ent_reg;
        rd_grp_reg <= grp_reg;
        if (req.start) begin
            list_reg <= req.list;
            addr_reg <= req.addr;
            vec_reg  <= valid_vec;
        end
    end

endmodule

`default_nettype wire

// File: rtl/packet_field_classifier.sv
// Packet field classifier: evaluates one header predicate per classify beat.
// Top level; holds the port bitmap memory and the item sequencer.
// Depends on pfc_pkg and pfc_mask_store.
//
// Usage:
//   Input beats arrive on s_valid/s_ready with the header fields and the
//   table write fields. A classify beat (func 0) yields one m_match beat on
//   m_valid/m_ready; table write beats yield nothing.
//   Items are worked one at a time. Protocol and ICMP tests put their result
//   in the output register by way of the result register, port bitmap tests
//   after one read of the bitmap memory, IP list tests after the scan of the
//   mask memory, which is read once per octet of each entry. A classify
//   beat holds s_ready low until its result enters the output register.
//   The next beat is accepted as soon as the sequencer is back in idle,
//   also while a result still waits in the output register; a stalled
//   receiver holds m_match and only blocks a later classify result.
//   After reset the block runs a clearing pass over all 16384 words of the
//   port bitmap memory, one word per cycle, with s_ready low. Entry valid bits
//   clear at once; the IP mask words hold nothing defined until written.
`timescale 1ns / 1ps
`default_nettype none

module packet_field_classifier
    import pfc_pkg::*;
#(
    parameter int IP_ENTRIES = IP_ENTRIES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_func,
    input  wire logic [4:0]  s_predicate,
    input  wire logic        s_use_source,
    input  wire logic [7:0]  s_protocol,
    input  wire logic [31:0] s_src_addr,
    input  wire logic [31:0] s_dst_addr,
    input  wire logic [15:0] s_src_port,
    input  wire logic [15:0] s_dst_port,
    input  wire logic [7:0]  s_icmp_kind,
    input  wire logic [2:0]  s_table_list,
    input  wire logic [10:0] s_table_addr,
    input  wire logic [31:0] s_table_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_match
);

    localparam int ENT_W   = (IP_ENTRIES > 1) ? $clog2(IP_ENTRIES) : 1;
    localparam int PDEPTH  = NUM_LISTS * PORT_WORDS;

    state_t                 state_reg, state_next;
    logic [PORT_ADDR_W-1:0] clr_reg, clr_next;
    logic                   res_reg, res_next;
    logic                   m_valid_reg, m_valid_next;
    logic                   m_match_reg, m_match_next;
    logic [4:0]             pbit_reg;
    logic [IP_ENTRIES-1:0]  valid_reg [NUM_LISTS];

    logic [31:0]            pmem [PDEPTH];
    logic [31:0]            prdata_reg;

    logic                   s_acc;
    logic                   is_classify;
    logic                   is_ip;
    logic                   is_port;
    logic                   fast_res;
    logic [31:0]            sel_addr;
    logic [15:0]            sel_port;
    logic [LIST_W-1:0]      ip_list;
    logic [LIST_W-1:0]      port_list;
    logic                   out_load;
    logic                   valid_we;

    logic                   pm_we;
    logic [PORT_ADDR_W-1:0] pm_waddr;
    logic [31:0]            pm_wdata;
    logic                   pm_re;
    logic [PORT_ADDR_W-1:0] pm_raddr;

    mask_wr_t               mask_wr;
    scan_req_t              scan_req;
    scan_rsp_t              scan_rsp;

    // Decode the input beat
    always_comb begin
        logic [4:0] ip_off;
        logic [4:0] port_off;
        logic       src;
        src         = s_use_source;
        ip_off      = s_predicate - PRED_IP0;
        port_off    = s_predicate - PRED_PORT0;
        ip_list     = ip_off[LIST_W-1:0];
        port_list   = port_off[LIST_W-1:0];
        sel_addr    = src ? s_src_addr : s_dst_addr;
        sel_port    = src ? s_src_port : s_dst_port;
        is_classify = (s_func == FUNC_CLASSIFY);
        is_ip       = (s_predicate >= PRED_IP0) && (s_predicate <= PRED_IP7);
        is_port     = (s_predicate >= PRED_PORT0) && (s_predicate <= PRED_PORT7);
        case (s_predicate)
            PRED_TCP:     fast_res = (s_protocol == PROTO_TCP);
            PRED_UDP:     fast_res = (s_protocol == PROTO_UDP);
            PRED_ICMP:    fast_res = (s_protocol == PROTO_ICMP);
            PRED_REQUEST: fast_res = src ? in_request_set(s_icmp_kind)
                                         : in_reply_set(s_icmp_kind);
            PRED_REPLY:   fast_res = src ? in_reply_set(s_icmp_kind)
                                         : in_request_set(s_icmp_kind);
            PRED_ERROR:   fast_res = in_error_set(s_icmp_kind) ? src : !src;
            PRED_OTHER:   fast_res = (in_request_set(s_icmp_kind) ||
                                      in_reply_set(s_icmp_kind) ||
                                      in_error_set(s_icmp_kind)) ? !src : src;
            default:      fast_res = 1'b0;
        endcase
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid && is_classify) begin
                    if (is_ip) begin
                        state_next = ST_SCAN;
                    end else if (is_port) begin
                        state_next = ST_PORT;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_PORT: begin
                state_next = ST_FINISH;
            end
            ST_SCAN: begin
                if (scan_rsp.done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer: handshake, memory strobes, scan start
    always_comb begin
        s_ready  = (state_reg == ST_IDLE);
        s_acc    = s_valid && s_ready;
        out_load = (state_reg == ST_FINISH) && (!m_valid_reg || m_ready);

        pm_we    = 1'b0;
        pm_waddr = {s_table_list, s_table_addr[PORT_WORD_W-1:0]};
        pm_wdata = s_table_data;
        case (state_reg)
            ST_CLEAR: begin
                pm_we    = 1'b1;
                pm_waddr = clr_reg;
                pm_wdata = '0;
            end
            ST_IDLE: begin
                pm_we = s_acc && (s_func == FUNC_PORT_WR);
            end
            default: begin
                pm_we = 1'b0;
            end
        endcase
        pm_re    = s_acc && is_classify && is_port;
        pm_raddr = {port_list, sel_port[15:5]};

        mask_wr.en   = s_acc && (s_func == FUNC_MASK_WR) &&
                       ({1'b0, s_table_addr[10:5]} < 7'(IP_ENTRIES));
        mask_wr.list = s_table_list;
        mask_wr.addr = s_table_addr;
        mask_wr.data = s_table_data;

        valid_we = s_acc && (s_func == FUNC_VALID_WR) &&
                   (s_table_addr < TADDR_W'(IP_ENTRIES));

        scan_req.start = s_acc && is_classify && is_ip;
        scan_req.list  = ip_list;
        scan_req.addr  = sel_addr;
    end

    // Result register and output stage
    always_comb begin
        clr_next     = clr_reg + PORT_ADDR_W'(1);
        res_next     = res_reg;
        case (state_reg)
            ST_IDLE: begin
                res_next = fast_res;
            end
            ST_PORT: begin
                res_next = prdata_reg[pbit_reg];
            end
            ST_SCAN: begin
                res_next = scan_rsp.hit;
            end
            default: begin
                res_next = res_reg;
            end
        endcase
        m_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
        m_match_next = out_load ? res_reg : m_match_reg;
    end

    // Port bitmap memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (pm_we) begin
            pmem[pm_waddr] <= pm_wdata;
        end
        if (pm_re) begin
            prdata_reg <= pmem[pm_raddr];
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_LISTS; i++) begin
                valid_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
            if (valid_we) begin
                valid_reg[s_table_list][s_table_addr[ENT_W-1:0]] <= s_table_data[0];
            end
        end
        res_reg     <= res_next;
        m_match_reg <= m_match_next;
        if (s_acc) begin
            pbit_reg <= sel_port[4:0];
        end
    end

    pfc_mask_store #(
        .IP_ENTRIES (IP_ENTRIES)
    ) u_mask_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr        (mask_wr),
        .req       (scan_req),
        .valid_vec (valid_reg[ip_list]),
        .rsp       (scan_rsp)
    );

    assign m_valid = m_valid_reg;
    assign m_match = m_match_reg;

endmodule

`default_nettype wire
